/* hdl/tsc_pkg.sv */
`default_nettype none

package tsc_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [5:0] FLAG_FIN = 6'h01;
    localparam logic [5:0] FLAG_SYN = 6'h02;
    localparam logic [5:0] FLAG_RST = 6'h04;
    localparam logic [5:0] FLAG_ACK = 6'h10;

    localparam logic [15:0] IP_HDR_BYTES = 16'd20;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LISTEN_PORT   = 2'd0,
        CFG_LISTEN_ENABLE = 2'd1,
        CFG_WINDOW_SIZE   = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_SYN_RCVD    = 4'd2,
        ST_ESTABLISHED = 4'd3,
        ST_FIN_WAIT1   = 4'd4,
        ST_FIN_WAIT2   = 4'd5,
        ST_CLOSE_WAIT  = 4'd6,
        ST_TIME_WAIT   = 4'd7,
        ST_LAST_ACK    = 4'd8,
        ST_CLOSING     = 4'd9
    } conn_state_t;

    typedef enum logic [1:0] {
        SK_CLOSED    = 2'd0,
        SK_OPENED    = 2'd1,
        SK_CONNECTED = 2'd2,
        SK_CLOSING   = 2'd3
    } sock_status_t;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_SEGMENT = 2'd1,
        KIND_IGNORE  = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic        func;
        logic [5:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dst_port;
        logic [15:0] ip_total_length;
        logic [5:0]  tcp_header_bytes;
        logic [15:0] timer_sample;
    } in_item_t;

    typedef struct packed {
        logic        matched;
        logic        send_reply;
        logic [5:0]  reply_flags;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dst_port;
        logic [3:0]  conn_state_out;
        logic [1:0]  socket_status_out;
        logic        data_ready;
        logic [15:0] data_bytes;
    } out_item_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [5:0]  seg_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] seg_src_port;
        logic [15:0] seg_dst_port;
        logic [15:0] payload_len;
        logic [15:0] timer_sample;
    } q_item_t;

endpackage

`default_nettype wire

/* hdl/tsc_if.sv */
`default_nettype none

interface tsc_item_if;
    logic              valid;
    logic              ready;
    tsc_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsc_result_if;
    logic               valid;
    logic               ready;
    tsc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/tsc_front.sv */
`default_nettype none

module tsc_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [tsc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tsc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  wire logic                                in_valid,
    input  wire tsc_pkg::in_item_t                   in_data,
    output logic                                     in_ready,
    input  wire logic                                q_ready,
    output logic                                     q_push,
    output tsc_pkg::q_item_t                         q_data
);

    logic [15:0] listen_port_reg;
    logic        listen_enable_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            listen_port_reg   <= '0;
            listen_enable_reg <= 1'b0;
        end else if (cfg_we) begin
            // The window register has no effect on any result, so its writes are dropped.
            unique case (tsc_pkg::cfg_index_t'(cfg_index))
                tsc_pkg::CFG_LISTEN_PORT:   listen_port_reg   <= cfg_wdata[15:0];
                tsc_pkg::CFG_LISTEN_ENABLE: listen_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    always_comb begin
        q_data.seg_flags    = in_data.seg_flags;
        q_data.seg_seq      = in_data.seg_seq;
        q_data.seg_ack      = in_data.seg_ack;
        q_data.seg_src_port = in_data.seg_src_port;
        q_data.seg_dst_port = in_data.seg_dst_port;
        q_data.timer_sample = in_data.timer_sample;
        q_data.payload_len  = in_data.ip_total_length - tsc_pkg::IP_HDR_BYTES
                              - {10'd0, in_data.tcp_header_bytes};
        if (in_data.func) begin
            q_data.kind = tsc_pkg::KIND_TICK;
        end else if (listen_enable_reg && (in_data.seg_dst_port == listen_port_reg)) begin
            q_data.kind = tsc_pkg::KIND_SEGMENT;
        end else begin
            q_data.kind = tsc_pkg::KIND_IGNORE;
        end
    end

endmodule

`default_nettype wire

/* hdl/tsc_queue.sv */
`default_nettype none

module tsc_queue #(
    parameter int DEPTH = tsc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire tsc_pkg::q_item_t push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  pop_valid,
    output tsc_pkg::q_item_t      pop_data
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(DEPTH);

    tsc_pkg::q_item_t mem [DEPTH];

    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_next;

    assign push_ready = (count_reg != COUNT_MAX);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/tsc_back.sv */
`default_nettype none

module tsc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire tsc_pkg::q_item_t q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    output tsc_pkg::out_item_t    out_data,
    input  wire logic             out_ready
);

    tsc_pkg::conn_state_t  state_reg, state_next, cur_state;
    tsc_pkg::sock_status_t sock_reg, sock_next, cur_sock;
    logic [31:0] local_seq_reg, local_seq_next;
    logic [31:0] remote_ack_reg, remote_ack_next;
    logic [31:0] unacked_seq_reg, unacked_seq_next;
    logic [15:0] isn_upper_reg, isn_upper_next;
    logic        pending_reg, pending_next;
    logic [15:0] pending_len_reg, pending_len_next;
    logic        out_valid_reg, out_valid_next;
    tsc_pkg::out_item_t out_data_reg, out_data_next;

    logic        send;
    logic        matched;
    logic [5:0]  code;
    logic        has_fin, has_syn, has_rst, has_ack;
    logic [31:0] seq_plus_payload;
    logic [31:0] seq_plus_one;
    logic [31:0] isn;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign has_fin = |(q_data.seg_flags & tsc_pkg::FLAG_FIN);
    assign has_syn = |(q_data.seg_flags & tsc_pkg::FLAG_SYN);
    assign has_rst = |(q_data.seg_flags & tsc_pkg::FLAG_RST);
    assign has_ack = |(q_data.seg_flags & tsc_pkg::FLAG_ACK);

    assign seq_plus_payload = q_data.seg_seq + {16'd0, q_data.payload_len};
    assign seq_plus_one     = q_data.seg_seq + 32'd1;
    assign isn              = {isn_upper_reg, q_data.timer_sample};

    always_comb begin
        state_next       = state_reg;
        sock_next        = sock_reg;
        local_seq_next   = local_seq_reg;
        remote_ack_next  = remote_ack_reg;
        unacked_seq_next = unacked_seq_reg;
        isn_upper_next   = isn_upper_reg;
        pending_next     = pending_reg;
        pending_len_next = pending_len_reg;
        send             = 1'b0;
        matched          = 1'b0;
        code             = '0;
        cur_state        = has_rst ? tsc_pkg::ST_CLOSED : state_reg;
        cur_sock         = has_rst ? tsc_pkg::SK_CLOSED : sock_reg;

        if (q_data.kind == tsc_pkg::KIND_TICK) begin
            isn_upper_next = isn_upper_reg + 16'd1;
        end else if (q_data.kind == tsc_pkg::KIND_SEGMENT) begin
            matched    = 1'b1;
            state_next = cur_state;
            sock_next  = cur_sock;
            unique case (cur_state) inside
                tsc_pkg::ST_CLOSED: begin
                    if (has_ack) begin
                        local_seq_next = q_data.seg_ack;
                        code           = tsc_pkg::FLAG_RST;
                    end else begin
                        local_seq_next  = '0;
                        remote_ack_next = seq_plus_payload + {31'd0, has_syn | has_fin};
                        code            = tsc_pkg::FLAG_RST | tsc_pkg::FLAG_ACK;
                    end
                    send       = 1'b1;
                    state_next = tsc_pkg::ST_LISTEN;
                end
                tsc_pkg::ST_LISTEN: begin
                    if (has_ack) begin
                        local_seq_next = q_data.seg_ack;
                        code           = tsc_pkg::FLAG_RST;
                        send           = 1'b1;
                    end else if (has_syn) begin
                        code             = tsc_pkg::FLAG_SYN | tsc_pkg::FLAG_ACK;
                        remote_ack_next  = seq_plus_one;
                        local_seq_next   = isn;
                        unacked_seq_next = isn + 32'd1;
                        state_next       = tsc_pkg::ST_SYN_RCVD;
                        sock_next        = tsc_pkg::SK_OPENED;
                        send             = 1'b1;
                    end
                end
                tsc_pkg::ST_SYN_RCVD: begin
                    if (has_syn) begin
                        state_next = tsc_pkg::ST_CLOSED;
                        sock_next  = tsc_pkg::SK_CLOSED;
                        code       = tsc_pkg::FLAG_RST;
                        send       = 1'b1;
                    end
                    if (has_ack) begin
                        local_seq_next = q_data.seg_ack;
                        state_next     = tsc_pkg::ST_ESTABLISHED;
                        sock_next      = tsc_pkg::SK_CONNECTED;
                    end
                end
                tsc_pkg::ST_ESTABLISHED: begin
                    if (has_syn) begin
                        state_next = tsc_pkg::ST_CLOSED;
                        sock_next  = tsc_pkg::SK_CLOSED;
                        code       = tsc_pkg::FLAG_RST;
                        send       = 1'b1;
                    end else begin
                        local_seq_next  = q_data.seg_ack;
                        remote_ack_next = seq_plus_payload
                                          + {31'd0, (q_data.payload_len == '0)};
                        if (has_fin) begin
                            code       = tsc_pkg::FLAG_ACK;
                            send       = 1'b1;
                            state_next = tsc_pkg::ST_CLOSE_WAIT;
                            sock_next  = tsc_pkg::SK_CLOSING;
                        end else if (has_ack) begin
                            if (cur_sock == tsc_pkg::SK_CLOSING) begin
                                code       = tsc_pkg::FLAG_FIN;
                                send       = 1'b1;
                                state_next = tsc_pkg::ST_FIN_WAIT1;
                            end else if (q_data.payload_len != '0) begin
                                pending_next     = 1'b1;
                                pending_len_next = q_data.payload_len;
                                code             = tsc_pkg::FLAG_ACK;
                                send             = 1'b1;
                            end
                        end
                    end
                end
                tsc_pkg::ST_FIN_WAIT1: begin
                    if (has_fin) begin
                        sock_next       = tsc_pkg::SK_CLOSING;
                        code            = tsc_pkg::FLAG_ACK;
                        state_next      = tsc_pkg::ST_CLOSING;
                        send            = 1'b1;
                        local_seq_next  = q_data.seg_ack;
                        remote_ack_next = seq_plus_one;
                    end else if (has_ack) begin
                        sock_next  = tsc_pkg::SK_CLOSING;
                        state_next = tsc_pkg::ST_FIN_WAIT2;
                    end
                end
                tsc_pkg::ST_FIN_WAIT2, tsc_pkg::ST_CLOSING: begin
                    if (has_fin) begin
                        code            = tsc_pkg::FLAG_ACK;
                        state_next      = tsc_pkg::ST_TIME_WAIT;
                        send            = 1'b1;
                        local_seq_next  = q_data.seg_ack;
                        remote_ack_next = seq_plus_one;
                    end
                end
                tsc_pkg::ST_CLOSE_WAIT: begin
                    if (has_fin) begin
                        code            = tsc_pkg::FLAG_FIN;
                        state_next      = tsc_pkg::ST_LAST_ACK;
                        send            = 1'b1;
                        local_seq_next  = q_data.seg_ack;
                        remote_ack_next = seq_plus_one;
                    end
                end
                tsc_pkg::ST_TIME_WAIT: begin
                    state_next = tsc_pkg::ST_CLOSED;
                end
                tsc_pkg::ST_LAST_ACK: begin
                    if (has_ack) begin
                        state_next = tsc_pkg::ST_CLOSED;
                    end
                end
                default: begin
                    state_next = tsc_pkg::ST_CLOSED;
                    sock_next  = tsc_pkg::SK_CLOSED;
                end
            endcase
        end

        out_data_next.matched           = matched;
        out_data_next.send_reply        = send;
        out_data_next.reply_flags       = send ? code : '0;
        out_data_next.reply_seq         = send ? local_seq_next : '0;
        out_data_next.reply_ack         = send ? remote_ack_next : '0;
        out_data_next.reply_src_port    = send ? q_data.seg_dst_port : '0;
        out_data_next.reply_dst_port    = send ? q_data.seg_src_port : '0;
        out_data_next.conn_state_out    = state_next;
        out_data_next.socket_status_out = sock_next;
        out_data_next.data_ready        = pending_next;
        out_data_next.data_bytes        = pending_len_next;

        if (q_pop) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg       <= tsc_pkg::ST_CLOSED;
            sock_reg        <= tsc_pkg::SK_CLOSED;
            local_seq_reg   <= '0;
            remote_ack_reg  <= '0;
            unacked_seq_reg <= '0;
            isn_upper_reg   <= '0;
            pending_reg     <= 1'b0;
            pending_len_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                state_reg       <= state_next;
                sock_reg        <= sock_next;
                local_seq_reg   <= local_seq_next;
                remote_ack_reg  <= remote_ack_next;
                unacked_seq_reg <= unacked_seq_next;
                isn_upper_reg   <= isn_upper_next;
                pending_reg     <= pending_next;
                pending_len_reg <= pending_len_next;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/tcp_server_connection_fsm.sv */
// Server-side TCP connection machine for one client of one listening port.
// The item channel carries either a parsed segment header (func = 0) or a
// service tick (func = 1); the result channel returns exactly one result
// transaction per item, in order, with the reply header fields, a send
// strobe and the connection state after the update.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while
// the block is idle: index 0 is the listening port, 1 the enable bit and
// 2 the window size. Writes to index 3 are ignored.
// An item is classified by the front end as it is accepted and enters a
// small queue. The back end takes one queued item per cycle while the
// output register is empty or being read, updates the connection state
// and loads the output register. Items pass through the queue and then
// the output register, one per cycle while the receiver takes results.
// When the receiver stalls, the result holds in the output register and
// the queue keeps accepting items until it is full; item ready then drops.
// Reset clears the connection state, sequence numbers, pending data, the
// queue and the configuration; the window size reaches no result field
// and is not stored.

`default_nettype none

module tcp_server_connection_fsm #(
    parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [tsc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [tsc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    tsc_item_if.sink                                item,
    tsc_result_if.source                            result
);

    logic             q_push;
    logic             q_ready;
    logic             q_pop;
    logic             q_valid;
    tsc_pkg::q_item_t q_push_data;
    tsc_pkg::q_item_t q_pop_data;

    tsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (item.valid),
        .in_data   (item.data),
        .in_ready  (item.ready),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    tsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_pop_data)
    );

    tsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (result.valid),
        .out_data  (result.data),
        .out_ready (result.ready)
    );

endmodule

`default_nettype wire

/* dv/tsc_reply_checker.sv */
module tsc_reply_checker
    import tsc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    tsc_item_if                            item,
    tsc_result_if                          result,
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] cfg_port;
    logic        cfg_en;
    logic [15:0] cfg_window;

    logic [3:0]  st;
    logic [1:0]  sk;
    logic [31:0] lseq;
    logic [31:0] rack;
    logic [31:0] unacked;
    logic [15:0] isn_hi;
    logic        pend;
    logic [15:0] pend_len;

    out_item_t   pending_replies[$];

    function automatic bit has_flag(input logic [5:0] f, input logic [5:0] m);
        return (f & m) != 6'd0;
    endfunction

    function automatic string reply_text(input out_item_t r);
        return $sformatf({"matched=%0b send=%0b flags=%02h seq=%08h ack=%08h sport=%04h ",
                          "dport=%04h state=%0d sock=%0d data_ready=%0b data_bytes=%0d"},
                         r.matched, r.send_reply, r.reply_flags, r.reply_seq, r.reply_ack,
                         r.reply_src_port, r.reply_dst_port, r.conn_state_out,
                         r.socket_status_out, r.data_ready, r.data_bytes);
    endfunction

    function automatic out_item_t predict_reply(input in_item_t x);
        out_item_t   r;
        logic [15:0] plen;
        logic [3:0]  nxt;
        logic [5:0]  code;
        logic        tx;
        r    = '0;
        code = '0;
        tx   = 1'b0;
        plen = x.ip_total_length - IP_HDR_BYTES - {10'd0, x.tcp_header_bytes};
        if (x.func) begin
            isn_hi = isn_hi + 16'd1;
        end
        else if (cfg_en && x.seg_dst_port == cfg_port) begin
            r.matched = 1'b1;
            if (has_flag(x.seg_flags, FLAG_RST)) begin
                st = ST_CLOSED;
                sk = SK_CLOSED;
            end
            nxt = st;
            case (st)
                ST_CLOSED:
                begin
                    if (has_flag(x.seg_flags, FLAG_ACK)) begin
                        lseq = x.seg_ack;
                        code = FLAG_RST;
                    end
                    else begin
                        lseq = '0;
                        rack = x.seg_seq + plen;
                        if (has_flag(x.seg_flags, FLAG_SYN | FLAG_FIN))
                            rack = rack + 32'd1;
                        code = FLAG_RST | FLAG_ACK;
                    end
                    tx  = 1'b1;
                    nxt = ST_LISTEN;
                end
                ST_LISTEN:
                begin
                    if (has_flag(x.seg_flags, FLAG_ACK)) begin
                        lseq = x.seg_ack;
                        code = FLAG_RST;
                        tx   = 1'b1;
                    end
                    else if (has_flag(x.seg_flags, FLAG_SYN)) begin
                        code    = FLAG_SYN | FLAG_ACK;
                        rack    = x.seg_seq + 32'd1;
                        lseq    = {isn_hi, x.timer_sample};
                        unacked = lseq + 32'd1;
                        nxt     = ST_SYN_RCVD;
                        sk      = SK_OPENED;
                        tx      = 1'b1;
                    end
                end
                ST_SYN_RCVD:
                begin
                    if (has_flag(x.seg_flags, FLAG_SYN)) begin
                        nxt  = ST_CLOSED;
                        sk   = SK_CLOSED;
                        code = FLAG_RST;
                        tx   = 1'b1;
                    end
                    if (has_flag(x.seg_flags, FLAG_ACK)) begin
                        lseq = x.seg_ack;
                        nxt  = ST_ESTABLISHED;
                        sk   = SK_CONNECTED;
                    end
                end
                ST_ESTABLISHED:
                begin
                    if (has_flag(x.seg_flags, FLAG_SYN)) begin
                        nxt  = ST_CLOSED;
                        sk   = SK_CLOSED;
                        code = FLAG_RST;
                        tx   = 1'b1;
                    end
                    else begin
                        lseq = x.seg_ack;
                        rack = x.seg_seq + plen;
                        if (plen == 16'd0)
                            rack = rack + 32'd1;
                        if (has_flag(x.seg_flags, FLAG_FIN)) begin
                            code = FLAG_ACK;
                            tx   = 1'b1;
                            nxt  = ST_CLOSE_WAIT;
                            sk   = SK_CLOSING;
                        end
                        else if (has_flag(x.seg_flags, FLAG_ACK)) begin
                            if (sk == SK_CLOSING) begin
                                code = FLAG_FIN;
                                tx   = 1'b1;
                                nxt  = ST_FIN_WAIT1;
                            end
                            else if (plen != 16'd0) begin
                                pend     = 1'b1;
                                pend_len = plen;
                                code     = FLAG_ACK;
                                tx       = 1'b1;
                            end
                        end
                    end
                end
                ST_FIN_WAIT1:
                begin
                    if (has_flag(x.seg_flags, FLAG_FIN)) begin
                        sk   = SK_CLOSING;
                        code = FLAG_ACK;
                        nxt  = ST_CLOSING;
                        tx   = 1'b1;
                        lseq = x.seg_ack;
                        rack = x.seg_seq + 32'd1;
                    end
                    else if (has_flag(x.seg_flags, FLAG_ACK)) begin
                        sk  = SK_CLOSING;
                        nxt = ST_FIN_WAIT2;
                    end
                end
                ST_FIN_WAIT2, ST_CLOSING:
                begin
                    if (has_flag(x.seg_flags, FLAG_FIN)) begin
                        code = FLAG_ACK;
                        nxt  = ST_TIME_WAIT;
                        tx   = 1'b1;
                        lseq = x.seg_ack;
                        rack = x.seg_seq + 32'd1;
                    end
                end
                ST_CLOSE_WAIT:
                begin
                    if (has_flag(x.seg_flags, FLAG_FIN)) begin
                        code = FLAG_FIN;
                        nxt  = ST_LAST_ACK;
                        tx   = 1'b1;
                        lseq = x.seg_ack;
                        rack = x.seg_seq + 32'd1;
                    end
                end
                ST_TIME_WAIT:
                begin
                    nxt = ST_CLOSED;
                end
                ST_LAST_ACK:
                begin
                    if (has_flag(x.seg_flags, FLAG_ACK))
                        nxt = ST_CLOSED;
                end
                default:
                begin
                    nxt = ST_CLOSED;
                    sk  = SK_CLOSED;
                end
            endcase
            st = nxt;
            if (tx) begin
                r.send_reply     = 1'b1;
                r.reply_flags    = code;
                r.reply_seq      = lseq;
                r.reply_ack      = rack;
                r.reply_src_port = x.seg_dst_port;
                r.reply_dst_port = x.seg_src_port;
            end
        end
        r.conn_state_out    = st;
        r.socket_status_out = sk;
        r.data_ready        = pend;
        r.data_bytes        = pend_len;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        out_item_t want;
        if (!rst_n) begin
            cfg_port   = '0;
            cfg_en     = 1'b0;
            cfg_window = 16'd1460;
            st         = ST_CLOSED;
            sk         = SK_CLOSED;
            lseq       = '0;
            rack       = '0;
            unacked    = '0;
            isn_hi     = '0;
            pend       = 1'b0;
            pend_len   = '0;
            pending_replies.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LISTEN_PORT:   cfg_port   = cfg_wdata;
                    CFG_LISTEN_ENABLE: cfg_en     = cfg_wdata[0];
                    CFG_WINDOW_SIZE:   cfg_window = cfg_wdata;
                    default: ;
                endcase
            end
            if (item.valid && item.ready)
                pending_replies.push_back(predict_reply(item.data));
            if (result.valid && result.ready) begin
                if (pending_replies.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result transaction: %s", $realtime,
                                 reply_text(result.data));
                    mismatches = mismatches + 1;
                end
                else begin
                    want = pending_replies.pop_front();
                    if (result.data !== want) begin
                        if (mismatches < 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    expected %s", reply_text(want));
                            $display("    actual   %s", reply_text(result.data));
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            outstanding <= pending_replies.size();
        end
    end

endmodule

/* dv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsc_pkg::*;

    localparam logic [5:0] FLAG_PSH = 6'h08;
    localparam logic [5:0] FLAG_URG = 6'h20;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    tsc_item_if   item_ch();
    tsc_result_if result_ch();

    int mismatches;
    int outstanding;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    bit hold_req;

    tcp_server_connection_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    tsc_reply_checker reply_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item        (item_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // The receiver stalls at random; on request it holds off for a long stretch.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (80) @(posedge clk);
                hold_req = 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic in_item_t make_segment(input logic [5:0] flags, input logic [15:0] dport,
                                              input logic [15:0] plen);
        in_item_t x;
        x.func             = 1'b0;
        x.seg_flags        = flags;
        x.seg_seq          = $urandom;
        x.seg_ack          = $urandom;
        x.seg_src_port     = 16'($urandom);
        x.seg_dst_port     = dport;
        x.tcp_header_bytes = 6'($urandom_range(60, 20));
        x.ip_total_length  = IP_HDR_BYTES + {10'd0, x.tcp_header_bytes} + plen;
        x.timer_sample     = 16'($urandom);
        return x;
    endfunction

    function automatic in_item_t make_tick();
        in_item_t x;
        x      = make_segment(6'($urandom_range(63)), 16'($urandom), 16'($urandom));
        x.func = 1'b1;
        return x;
    endfunction

    function automatic logic [15:0] data_length();
        if ($urandom_range(4) == 0)
            return 16'd0;
        return 16'($urandom_range(1460, 1));
    endfunction

    task automatic send_item(input in_item_t x);
        int gap;
        item_ch.valid <= 1'b1;
        item_ch.data  <= x;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] port, input logic en,
                                input logic [15:0] window);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LISTEN_PORT;
        cfg_wdata <= port;
        @(posedge clk);
        cfg_index <= CFG_LISTEN_ENABLE;
        cfg_wdata <= {15'd0, en};
        @(posedge clk);
        cfg_index <= CFG_WINDOW_SIZE;
        cfg_wdata <= window;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 62;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 62;
            end
            default:
            begin
                send_idle_pct  = 36;
                recv_stall_pct = 36;
            end
        endcase
    endtask

    task automatic send_noise(input logic [15:0] port);
        in_item_t x;
        case ($urandom_range(9))
            0, 1, 2: x = make_tick();
            3, 4, 5:
            begin
                x = make_segment(6'($urandom_range(63)), port, 16'd0);
                x.ip_total_length = 16'($urandom);
            end
            6, 7: x = make_segment(6'($urandom_range(63)), 16'($urandom), data_length());
            default: x = make_segment(FLAG_RST | 6'($urandom_range(63)), port, data_length());
        endcase
        send_item(x);
    endtask

    // Opens a connection from a forced close, moves data, then ends it in one of
    // several ways.
    task automatic run_session(input logic [15:0] port);
        int       n;
        logic [5:0] extra;
        extra = 6'($urandom_range(63));
        send_item(make_segment(FLAG_RST | (extra & (FLAG_ACK | FLAG_SYN | FLAG_FIN)), port,
                               data_length()));
        extra = 6'($urandom_range(63));
        send_item(make_segment(FLAG_SYN | (extra & (FLAG_FIN | FLAG_PSH | FLAG_URG)), port,
                               16'd0));
        if ($urandom_range(9) == 0)
            send_item(make_tick());
        extra = 6'($urandom_range(63));
        send_item(make_segment(FLAG_ACK | (extra & (FLAG_PSH | FLAG_URG)), port, 16'd0));
        n = $urandom_range(6);
        repeat (n)
        begin
            extra = 6'($urandom_range(63));
            if ($urandom_range(9) == 0)
                send_noise(port);
            send_item(make_segment(FLAG_ACK | (extra & (FLAG_PSH | FLAG_URG)), port,
                                   data_length()));
        end
        case ($urandom_range(3))
            0:
            begin
                send_item(make_segment(FLAG_FIN | FLAG_ACK, port, 16'd0));
                if ($urandom_range(1))
                    send_item(make_segment(FLAG_ACK, port, 16'd0));
                send_item(make_segment(FLAG_FIN | FLAG_ACK, port, 16'd0));
                if ($urandom_range(1))
                    send_item(make_segment(6'd0, port, 16'd0));
                send_item(make_segment(FLAG_ACK, port, 16'd0));
            end
            1: send_item(make_segment(FLAG_SYN | 6'($urandom_range(63) & FLAG_ACK), port,
                                      16'd0));
            2: send_item(make_segment(FLAG_RST, port, data_length()));
            default: ;
        endcase
    endtask

    task automatic run_directed(input logic [15:0] port);
        in_item_t x;
        send_item(make_tick());
        send_item(make_segment(FLAG_SYN, ~port, 16'd0));
        x = make_segment(FLAG_ACK, port, 16'd0);
        x.seg_seq = 32'h0; x.seg_ack = 32'hFFFF_FFFF; x.seg_src_port = 16'h0;
        x.tcp_header_bytes = 6'd20; x.ip_total_length = 16'd40; x.timer_sample = 16'h0;
        send_item(x);
        x = make_segment(FLAG_ACK, port, 16'd0);
        x.seg_ack = 32'h0; x.seg_src_port = 16'hFFFF;
        send_item(x);
        send_item(make_segment(6'd0, port, 16'd0));
        x = make_segment(FLAG_SYN, port, 16'd0);
        x.seg_seq = 32'hFFFF_FFFF; x.timer_sample = 16'hFFFF;
        send_item(x);
        send_item(make_segment(FLAG_SYN, port, 16'd0));
        x = make_segment(FLAG_SYN, port, 16'd0);
        x.seg_seq = 32'hFFFF_FFFF;
        send_item(x);
        x = make_segment(FLAG_SYN, port, 16'd0);
        x.timer_sample = 16'h0;
        send_item(x);
        send_item(make_segment(6'd0, port, 16'd0));
        send_item(make_segment(FLAG_ACK, port, 16'd0));
        send_item(make_segment(FLAG_ACK | FLAG_PSH, port, 16'd100));
        send_item(make_segment(FLAG_ACK, port, 16'd0));
        x = make_segment(6'd0, port, 16'd0);
        x.ip_total_length = 16'd0;
        send_item(x);
        x = make_segment(FLAG_ACK, port, 16'd0);
        x.ip_total_length = 16'd0; x.tcp_header_bytes = 6'd60;
        send_item(x);
        send_item(make_segment(FLAG_FIN | FLAG_ACK, port, 16'd0));
        send_item(make_segment(FLAG_ACK, port, 16'd0));
        send_item(make_segment(FLAG_FIN, port, 16'd0));
        send_item(make_segment(6'd0, port, 16'd0));
        send_item(make_segment(FLAG_ACK, port, 16'd0));
        send_item(make_segment(6'h3F, port, 16'h0));
        send_item(make_segment(FLAG_SYN | FLAG_URG, port, 16'd0));
        send_item(make_segment(FLAG_ACK, port, 16'd0));
        send_item(make_segment(FLAG_RST, port, 16'd12));
        send_item(make_segment(FLAG_SYN | FLAG_FIN, port, 16'd5));
    endtask

    initial
    begin
        logic [15:0] port;
        int          budget;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_LISTEN_PORT;
        cfg_wdata      = '0;
        item_ch.valid  = 1'b0;
        item_ch.data   = '0;
        hold_req       = 1'b0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(16'hFFFF, 1'b1, 16'd0);
        run_directed(16'hFFFF);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            port = (ph == 0) ? 16'h0 : (ph == 1) ? 16'hFFFF : 16'($urandom);
            write_config(port, ph != 5,
                         (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0 : 16'($urandom));
            set_idling(ph % 4);
            if (ph == 2)
                hold_req = 1'b1;
            budget = items_sent + ((ph == 5) ? 30 : 260);
            while (items_sent < budget)
            begin
                if (ph != 5 && $urandom_range(3) != 0)
                    run_session(port);
                else
                    send_noise(port);
            end
            drain();
        end

        port = 16'($urandom);
        write_config(port, 1'b1, 16'd1460);
        set_idling(0);
        run_session(port);
        set_idling(3);
        repeat (4) run_session(port);
        drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
